/* src/atp_pkg.sv */
// Shared constants, types and coefficient table of the atan2 polynomial unit.
`default_nettype none

package atp_pkg;

  localparam int unsigned CoordWidthDef = 16;
  localparam int unsigned AngleFracDef  = 13;
  localparam int unsigned AngleWidth    = 16;
  localparam int unsigned RatioFrac     = 16;
  localparam int unsigned QuotWidth     = RatioFrac + 1;
  localparam int unsigned AccWidth      = 19;
  localparam int unsigned CoefCount     = 7;
  localparam logic [63:0] PiQ61         = 64'h6487ED5110B4611A;

  typedef struct packed {
    logic ybig;
    logic xneg;
    logic yneg;
    logic zero;
  } atp_flags_t;

  // Minimax coefficients with 16 fraction bits, highest order first.
  function automatic logic signed [AccWidth-1:0] poly_coef(input int unsigned idx);
    logic signed [AccWidth-1:0] c;
    case (idx)
      0:       c = 19'sd473;
      1:       c = -19'sd2298;
      2:       c = 19'sd5353;
      3:       c = -19'sd8765;
      4:       c = 19'sd13013;
      5:       c = -19'sd21840;
      default: c = 19'sd65536;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/atp_coord_if.sv */
// Handshake channel that carries one coordinate pair.
`default_nettype none

interface atp_coord_if #(
  parameter int unsigned COORD_WIDTH = atp_pkg::CoordWidthDef
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] coord_y;
  logic signed [COORD_WIDTH-1:0] coord_x;

  modport source (output valid, output coord_y, output coord_x, input ready);
  modport sink   (input valid, input coord_y, input coord_x, output ready);
endinterface

`default_nettype wire

/* src/atp_angle_if.sv */
// Handshake channel that carries one angle result.
`default_nettype none

interface atp_angle_if;
  logic                                valid;
  logic                                ready;
  logic signed [atp_pkg::AngleWidth-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

/* src/atp_div_cell.sv */
// One restoring-division cell: resolves one quotient bit of the ratio.
`default_nettype none

module atp_div_cell #(
  parameter int unsigned COORD_WIDTH = atp_pkg::CoordWidthDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                en_next_i,
  output logic                               en_o,
  input  wire                                valid_i,
  input  atp_pkg::atp_flags_t                flags_i,
  input  wire  [COORD_WIDTH-1:0]             big_i,
  input  wire  [COORD_WIDTH:0]               rem_i,
  input  wire  [atp_pkg::QuotWidth-1:0]      quot_i,
  output logic                               valid_o,
  output atp_pkg::atp_flags_t                flags_o,
  output logic [COORD_WIDTH-1:0]             big_o,
  output logic [COORD_WIDTH:0]               rem_o,
  output logic [atp_pkg::QuotWidth-1:0]      quot_o
);
  import atp_pkg::*;

  logic                   valid_q;
  atp_flags_t             flags_q;
  logic [COORD_WIDTH-1:0] big_q;
  logic [COORD_WIDTH:0]   rem_q;
  logic [QuotWidth-1:0]   quot_q;

  logic [COORD_WIDTH+1:0] trial;
  logic                   qbit;
  logic [COORD_WIDTH:0]   rem_sel;

  assign en_o = !valid_q || en_next_i;

  always_comb begin
    trial   = {1'b0, rem_i} - {2'b00, big_i};
    qbit    = !trial[COORD_WIDTH+1];
    rem_sel = qbit ? trial[COORD_WIDTH:0] : rem_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

  // The remainder stays below the divisor, so the doubled value fits.
  always_ff @(posedge clk_i) begin
    if (en_o) begin
      flags_q <= flags_i;
      big_q   <= big_i;
      rem_q   <= {rem_sel[COORD_WIDTH-1:0], 1'b0};
      quot_q  <= {quot_i[QuotWidth-2:0], qbit};
    end
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;
  assign big_o   = big_q;
  assign rem_o   = rem_q;
  assign quot_o  = quot_q;

endmodule

`default_nettype wire

/* src/atp_horner_cell.sv */
// One Horner cell: acc = round(acc * t2) + coefficient.
`default_nettype none

module atp_horner_cell #(
  parameter int unsigned COEF_IDX = 1
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   en_next_i,
  output logic                                  en_o,
  input  wire                                   valid_i,
  input  atp_pkg::atp_flags_t                   flags_i,
  input  wire  [atp_pkg::QuotWidth-1:0]         t_i,
  input  wire  [atp_pkg::QuotWidth-1:0]         t2_i,
  input  wire  signed [atp_pkg::AccWidth-1:0]   acc_i,
  output logic                                  valid_o,
  output atp_pkg::atp_flags_t                   flags_o,
  output logic [atp_pkg::QuotWidth-1:0]         t_o,
  output logic [atp_pkg::QuotWidth-1:0]         t2_o,
  output logic signed [atp_pkg::AccWidth-1:0]   acc_o
);
  import atp_pkg::*;

  localparam int unsigned ProdWidth = AccWidth + QuotWidth + 1;

  logic                        valid_q;
  atp_flags_t                  flags_q;
  logic [QuotWidth-1:0]        t_q;
  logic [QuotWidth-1:0]        t2_q;
  logic signed [AccWidth-1:0]  acc_q;

  logic signed [ProdWidth-1:0] prod;
  logic signed [ProdWidth-1:0] prod_rnd;
  logic signed [AccWidth-1:0]  acc_d;

  assign en_o = !valid_q || en_next_i;

  always_comb begin
    prod     = acc_i * $signed({1'b0, t2_i});
    prod_rnd = prod + (ProdWidth'(1) <<< (RatioFrac - 1));
    acc_d    = $signed(prod_rnd[AccWidth+RatioFrac-1:RatioFrac]) + poly_coef(COEF_IDX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      flags_q <= flags_i;
      t_q     <= t_i;
      t2_q    <= t2_i;
      acc_q   <= acc_d;
    end
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;
  assign t_o     = t_q;
  assign t2_o    = t2_q;
  assign acc_o   = acc_q;

endmodule

`default_nettype wire

/* src/atan2_polynomial_unit.sv */
// Top level of the atan2 unit: a chain of division and Horner cells.
// Stages from an input transfer to the result: 1 front stage, 17 division cells,
// 1 squaring stage, 6 Horner cells, 1 multiply stage, 1 rounding stage, 1 output register.
// Throughput: one coordinate pair per cycle while the output is not stalled; every
// stage advances when it is empty or its successor advances, so bubbles close up
// under back-pressure.
// Reset clears all valid bits at once, so the unit is ready as soon as reset is released.
`default_nettype none

module atan2_polynomial_unit #(
  parameter int unsigned COORD_WIDTH     = atp_pkg::CoordWidthDef,
  parameter int unsigned ANGLE_FRAC_BITS = atp_pkg::AngleFracDef
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  atp_coord_if.sink    coord_i,
  atp_angle_if.source  angle_o
);
  import atp_pkg::*;

  localparam int unsigned W         = COORD_WIDTH;
  localparam int unsigned ProdWidth = AccWidth + QuotWidth + 1;
  localparam int unsigned AW        = ProdWidth + 1;
  localparam int unsigned Kshift    = 2 * RatioFrac - ANGLE_FRAC_BITS;
  localparam logic [63:0] PiRaw  =
    (PiQ61 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
  localparam logic [63:0] HpiRaw =
    (PiQ61 + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] PiF    = $signed(PiRaw[AW-1:0]);
  localparam logic signed [AW-1:0] HpiF   = $signed(HpiRaw[AW-1:0]);
  localparam logic signed [AW-1:0] SatMax = AW'(32767);
  localparam logic signed [AW-1:0] SatMin = -AW'(32768);

  // Front stage: magnitudes and octant selection.
  logic [W-1:0] raw_y, raw_x, mag_y, mag_x, big, small_mag;
  atp_flags_t   front_flags;
  logic         front_en;
  logic         front_valid_q;
  atp_flags_t   front_flags_q;
  logic [W-1:0] front_big_q;
  logic [W:0]   front_rem_q;

  // Division chain, index 0 is the front stage.
  logic                 dv     [0:QuotWidth];
  atp_flags_t           dflags [0:QuotWidth];
  logic [W-1:0]         dbig   [0:QuotWidth];
  logic [W:0]           drem   [0:QuotWidth];
  logic [QuotWidth-1:0] dquot  [0:QuotWidth];
  logic                 den    [1:QuotWidth+1];

  // Squaring stage.
  logic [2*QuotWidth-1:0] sq;
  logic [QuotWidth-1:0]   t2;
  logic                   sq_en;

  // Horner chain, index 0 is the squaring stage.
  logic                       hv     [0:CoefCount-1];
  atp_flags_t                 hflags [0:CoefCount-1];
  logic [QuotWidth-1:0]       ht     [0:CoefCount-1];
  logic [QuotWidth-1:0]       ht2    [0:CoefCount-1];
  logic signed [AccWidth-1:0] hacc   [0:CoefCount-1];
  logic                       hen    [1:CoefCount];

  // Multiply, rounding and output stages.
  logic                        mul_en, rnd_en, out_en;
  logic                        mul_valid_q, rnd_valid_q, out_valid_q;
  atp_flags_t                  mul_flags_q, rnd_flags_q;
  logic signed [ProdWidth-1:0] mul_r_q;
  logic signed [ProdWidth-1:0] rnd_sum;
  logic signed [AW-1:0]        rnd_a, rnd_a_d;
  logic signed [AW-1:0]        rnd_a_q;
  logic signed [AW-1:0]        out_b, out_c;
  logic [AngleWidth-1:0]       angle_d;
  logic [AngleWidth-1:0]       angle_q;

  // ---------------------------------------------------------------- front
  always_comb begin
    raw_y = coord_i.coord_y[W-1:0];
    raw_x = coord_i.coord_x[W-1:0];
    // The most negative value maps onto its exact unsigned magnitude.
    mag_y = raw_y[W-1] ? (~raw_y + W'(1)) : raw_y;
    mag_x = raw_x[W-1] ? (~raw_x + W'(1)) : raw_x;
    front_flags.ybig = mag_y > mag_x;
    front_flags.xneg = raw_x[W-1];
    front_flags.yneg = raw_y[W-1];
    big       = front_flags.ybig ? mag_y : mag_x;
    small_mag = front_flags.ybig ? mag_x : mag_y;
    front_flags.zero = (big == '0);
  end

  assign front_en      = !front_valid_q || den[1];
  assign coord_i.ready = front_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (front_en) begin
      front_valid_q <= coord_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_en) begin
      front_flags_q <= front_flags;
      front_big_q   <= big;
      front_rem_q   <= {1'b0, small_mag};
    end
  end

  assign dv[0]     = front_valid_q;
  assign dflags[0] = front_flags_q;
  assign dbig[0]   = front_big_q;
  assign drem[0]   = front_rem_q;
  assign dquot[0]  = '0;

  // ---------------------------------------------------------------- divide
  for (genvar k = 1; k <= QuotWidth; k++) begin : g_div
    atp_div_cell #(
      .COORD_WIDTH (W)
    ) u_div_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_next_i (den[k+1]),
      .en_o      (den[k]),
      .valid_i   (dv[k-1]),
      .flags_i   (dflags[k-1]),
      .big_i     (dbig[k-1]),
      .rem_i     (drem[k-1]),
      .quot_i    (dquot[k-1]),
      .valid_o   (dv[k]),
      .flags_o   (dflags[k]),
      .big_o     (dbig[k]),
      .rem_o     (drem[k]),
      .quot_o    (dquot[k])
    );
  end

  // ---------------------------------------------------------------- square
  always_comb begin
    sq = dquot[QuotWidth] * dquot[QuotWidth];
    sq = sq + ((2*QuotWidth)'(1) << (RatioFrac - 1));
    t2 = sq[RatioFrac+QuotWidth-1:RatioFrac];
  end

  assign den[QuotWidth+1] = sq_en;
  assign sq_en            = !hv[0] || hen[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv[0] <= 1'b0;
    end else if (sq_en) begin
      hv[0] <= dv[QuotWidth];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_en) begin
      hflags[0] <= dflags[QuotWidth];
      ht[0]     <= dquot[QuotWidth];
      ht2[0]    <= t2;
      hacc[0]   <= poly_coef(0);
    end
  end

  // ---------------------------------------------------------------- Horner
  for (genvar k = 1; k < CoefCount; k++) begin : g_horner
    atp_horner_cell #(
      .COEF_IDX (k)
    ) u_horner_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_next_i (hen[k+1]),
      .en_o      (hen[k]),
      .valid_i   (hv[k-1]),
      .flags_i   (hflags[k-1]),
      .t_i       (ht[k-1]),
      .t2_i      (ht2[k-1]),
      .acc_i     (hacc[k-1]),
      .valid_o   (hv[k]),
      .flags_o   (hflags[k]),
      .t_o       (ht[k]),
      .t2_o      (ht2[k]),
      .acc_o     (hacc[k])
    );
  end

  assign hen[CoefCount] = mul_en;

  // ---------------------------------------------------------------- multiply
  assign mul_en = !mul_valid_q || rnd_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (mul_en) begin
      mul_valid_q <= hv[CoefCount-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      mul_flags_q <= hflags[CoefCount-1];
      mul_r_q     <= hacc[CoefCount-1] * $signed({1'b0, ht[CoefCount-1]});
    end
  end

  // ---------------------------------------------------------------- round
  always_comb begin
    rnd_sum = mul_r_q + (ProdWidth'(1) <<< (Kshift - 1));
    rnd_a   = AW'(rnd_sum >>> Kshift);
    rnd_a_d = mul_flags_q.ybig ? (HpiF - rnd_a) : rnd_a;
  end

  assign rnd_en = !rnd_valid_q || out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_valid_q <= 1'b0;
    end else if (rnd_en) begin
      rnd_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rnd_en) begin
      rnd_flags_q <= mul_flags_q;
      rnd_a_q     <= rnd_a_d;
    end
  end

  // ---------------------------------------------------------------- output
  always_comb begin
    out_b = rnd_flags_q.xneg ? (PiF - rnd_a_q) : rnd_a_q;
    out_c = rnd_flags_q.yneg ? -out_b : out_b;
    if (rnd_flags_q.zero) begin
      angle_d = '0;
    end else if (out_c > SatMax) begin
      angle_d = SatMax[AngleWidth-1:0];
    end else if (out_c < SatMin) begin
      angle_d = SatMin[AngleWidth-1:0];
    end else begin
      angle_d = out_c[AngleWidth-1:0];
    end
  end

  assign out_en = !out_valid_q || angle_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= rnd_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o.valid = out_valid_q;
  assign angle_o.angle = $signed(angle_q);

endmodule

`default_nettype wire

/* src/atp_checker.sv */
// Port-level checks of the atan2 unit, bound to its top level.
`default_nettype none

module atp_checker #(
  parameter int unsigned ANGLE_FRAC_BITS = atp_pkg::AngleFracDef
) (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                in_valid_i,
  input wire                                in_ready_i,
  input wire                                out_valid_i,
  input wire                                out_ready_i,
  input wire [atp_pkg::AngleWidth-1:0]      angle_i
);
  import atp_pkg::*;

  localparam logic [63:0] PiRaw =
    (PiQ61 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
  localparam int Bound   = (PiRaw > 64'd32767) ? 32767 : int'(PiRaw);
  localparam int BoundLo = (PiRaw > 64'd32768) ? -32768 : -int'(PiRaw);

  logic signed [AngleWidth-1:0] angle_s;
  assign angle_s = $signed(angle_i);

  // A stalled result holds its value until the transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(angle_i))
    else $error("result changed while stalled");

  // The input side only stalls when every stage is full and the output is stalled.
  a_ready_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // Every result lies within plus or minus pi, or at the saturation limits.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (int'(angle_s) <= Bound) && (int'(angle_s) >= BoundLo))
    else $error("angle out of range");

  // Ready drops only right after an input transfer has filled the front stage.
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i))
    else $error("input ready fell with no input transfer");

endmodule

bind atan2_polynomial_unit atp_checker #(
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_atp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (coord_i.valid),
  .in_ready_i  (coord_i.ready),
  .out_valid_i (angle_o.valid),
  .out_ready_i (angle_o.ready),
  .angle_i     (angle_o.angle)
);

`default_nettype wire

/* tb/atan2_polynomial_unit_tb.sv */
// Self-checking testbench of the atan2 polynomial unit with a bit-exact angle predictor.
`timescale 1ns / 100ps

module atan2_polynomial_unit_tb;
  import atp_pkg::*;

  localparam int unsigned CoordW     = CoordWidthDef;
  localparam int unsigned AngleFrac  = AngleFracDef;
  localparam int unsigned RoundShift = 2 * RatioFrac - AngleFrac;
  localparam int          RandomPairs = 1900;
  localparam int unsigned CycleLimit  = 500000;
  localparam int          TailCycles  = 40;

  typedef logic [CoordW-1:0]            coord_t;
  typedef logic signed [AngleWidth-1:0] angle_t;
  typedef longint unsigned              u64_t;

  typedef struct {
    coord_t y;
    coord_t x;
    bit     known;
    angle_t angle;
  } stim_row_t;

  logic clk;
  logic rst_n;

  atp_coord_if #(.COORD_WIDTH(CoordW)) coord_ch ();
  atp_angle_if angle_ch ();

  atan2_polynomial_unit #(
    .COORD_WIDTH    (CoordW),
    .ANGLE_FRAC_BITS(AngleFrac)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .coord_i(coord_ch),
    .angle_o(angle_ch)
  );

  angle_t      angle_due [$];
  stim_row_t   directed_rows [$];
  angle_t      oldest_angle;
  int          mismatches  = 0;
  int unsigned cycle_count = 0;
  int          burst_left  = 1;

  function automatic longint horner_coef(input int idx);
    case (idx)
      0:       return 473;
      1:       return -2298;
      2:       return 5353;
      3:       return -8765;
      4:       return 13013;
      5:       return -21840;
      default: return 65536;
    endcase
  endfunction

  function automatic angle_t predict_angle(input coord_t y, input coord_t x);
    logic   yneg, xneg, ybig;
    u64_t   ay, ax, big, sml, t, t2;
    longint acc, a, pi_f, hpi_f;
    yneg = y[CoordW-1];
    xneg = x[CoordW-1];
    // The most negative coordinate keeps its full magnitude.
    ay = yneg ? (u64_t'(1) << CoordW) - u64_t'(y) : u64_t'(y);
    ax = xneg ? (u64_t'(1) << CoordW) - u64_t'(x) : u64_t'(x);
    ybig = ay > ax;
    big  = ybig ? ay : ax;
    sml  = ybig ? ax : ay;
    pi_f  = longint'((PiQ61 + (u64_t'(1) << (60 - AngleFrac))) >> (61 - AngleFrac));
    hpi_f = longint'((PiQ61 + (u64_t'(1) << (61 - AngleFrac))) >> (62 - AngleFrac));
    if (big == 0) begin
      return '0;
    end
    t   = (sml << RatioFrac) / big;
    t2  = (t * t + (u64_t'(1) << (RatioFrac - 1))) >> RatioFrac;
    acc = horner_coef(0);
    for (int i = 1; i < CoefCount; i++) begin
      acc = ((acc * longint'(t2) + 64'sd32768) >>> RatioFrac) + horner_coef(i);
    end
    a = (acc * longint'(t) + (64'sd1 <<< (RoundShift - 1))) >>> RoundShift;
    if (ybig) a = hpi_f - a;
    if (xneg) a = pi_f - a;
    if (yneg) a = -a;
    if (a > 32767) a = 32767;
    if (a < -32768) a = -32768;
    return angle_t'(a);
  endfunction

  function automatic void add_row(input int y, input int x, input bit known = 1'b0,
                                  input int angle = 0);
    stim_row_t row;
    row.y     = coord_t'(y);
    row.x     = coord_t'(x);
    row.known = known;
    row.angle = angle_t'(angle);
    directed_rows.push_back(row);
  endfunction

  // A magnitude of 32768 only exists as a negative coordinate.
  function automatic coord_t signed_coord(input int mag);
    if (mag == 32768 || (mag != 0 && $urandom_range(0, 1) == 1)) begin
      return coord_t'(-mag);
    end
    return coord_t'(mag);
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h8001;
      3:       return 16'h0000;
      4:       return 16'h0001;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic random_pair(output coord_t y, output coord_t x);
    int m;
    int m2;
    coord_t swap;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        y = coord_t'($urandom);
        x = coord_t'($urandom);
      end
      3: begin
        y = signed_coord($urandom_range(0, 8));
        x = signed_coord($urandom_range(0, 8));
      end
      4, 5: begin
        // Magnitudes close to each other sit on the octant boundary.
        m  = $urandom_range(1, 32768);
        m2 = m + $urandom_range(0, 6) - 3;
        if (m2 < 0) m2 = 0;
        if (m2 > 32768) m2 = 32768;
        y = signed_coord(m);
        x = signed_coord(m2);
      end
      6: begin
        y = '0;
        x = signed_coord($urandom_range(0, 32768));
      end
      7: begin
        y = extreme_coord();
        x = extreme_coord();
      end
      8: begin
        y = signed_coord($urandom_range(1024, 32768));
        x = signed_coord($urandom_range(0, 16));
      end
      default: begin
        y = signed_coord($urandom_range(0, 1023));
        x = signed_coord($urandom_range(0, 1023));
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      swap = y;
      y    = x;
      x    = swap;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer, or after the idle gap that may follow it.
  task automatic transfer_pair(input coord_t y, input coord_t x, input bit known,
                               input angle_t typed);
    int gap;
    coord_ch.valid   = 1'b1;
    coord_ch.coord_y = y;
    coord_ch.coord_x = x;
    do @(posedge clk); while (coord_ch.ready !== 1'b1);
    angle_due.push_back(known ? typed : predict_angle(y, x));
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      if (gap > 0) begin
        coord_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic drain_results();
    coord_ch.valid = 1'b0;
    while (angle_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("atan2_polynomial_unit verification failed");
      $finish;
    end
  end

  // Receiver stalls follow a mode that is chosen anew at random for each span.
  initial begin
    int mode;
    int span;
    int period;
    int on_len;
    int phase;
    angle_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(20, 200);
      period = $urandom_range(2, 9);
      on_len = $urandom_range(1, period - 1);
      phase  = 0;
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       angle_ch.ready = 1'b1;
          1:       angle_ch.ready = 1'($urandom_range(0, 1));
          2:       angle_ch.ready = ($urandom_range(0, 3) != 0);
          default: angle_ch.ready = (phase < on_len);
        endcase
        phase = (phase + 1) % period;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && angle_ch.valid === 1'b1 && angle_ch.ready === 1'b1) begin
      if (angle_due.size() == 0) begin
        mismatches++;
        $display("%0t: angle expected none, got %0d", $time, angle_ch.angle);
      end else begin
        oldest_angle = angle_due.pop_front();
        if (angle_ch.angle !== oldest_angle) begin
          mismatches++;
          $display("%0t: angle expected %0d, got %0d", $time, oldest_angle, angle_ch.angle);
        end
      end
    end
  end

  initial begin
    coord_t y;
    coord_t x;
    coord_ch.valid   = 1'b0;
    coord_ch.coord_y = '0;
    coord_ch.coord_x = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Origin, axes and the most negative coordinate have angles known by inspection.
    add_row(0, 0, 1'b1, 0);
    add_row(0, 1, 1'b1, 0);
    add_row(0, 32767, 1'b1, 0);
    add_row(0, -1, 1'b1, 25736);
    add_row(0, -32768, 1'b1, 25736);
    add_row(1, 0, 1'b1, 12868);
    add_row(32767, 0, 1'b1, 12868);
    add_row(-1, 0, 1'b1, -12868);
    add_row(-32768, 0, 1'b1, -12868);
    // Equal magnitudes in all quadrants, then general points.
    add_row(1, 1);
    add_row(-1, -1);
    add_row(1, -1);
    add_row(-1, 1);
    add_row(32767, 32767);
    add_row(-32768, -32768);
    add_row(100, -100);
    add_row(-32768, 32767);
    add_row(32767, -32768);
    add_row(-32767, 32767);
    add_row(-32768, 1);
    add_row(1, -32768);
    add_row(3, 4);
    add_row(-4, 3);
    add_row(12345, -23456);

    foreach (directed_rows[i]) begin
      transfer_pair(directed_rows[i].y, directed_rows[i].x, directed_rows[i].known,
                    directed_rows[i].angle);
    end
    drain_results();

    for (int n = 0; n < RandomPairs; n++) begin
      if (n == RandomPairs / 2) begin
        drain_results();
      end
      random_pair(y, x);
      transfer_pair(y, x, 1'b0, '0);
    end

    drain_results();
    repeat (TailCycles) @(negedge clk);
    if (mismatches == 0) begin
      $display("atan2_polynomial_unit verification clean");
    end else begin
      $display("atan2_polynomial_unit verification failed");
    end
    $finish;
  end

endmodule
